### sv/huffman_bit_serial_decoder_core_defines.svh
// Assertion macros shared by the Huffman decoder RTL.
`ifndef HUFFMAN_BIT_SERIAL_DECODER_CORE_DEFINES_SVH
`define HUFFMAN_BIT_SERIAL_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define HBSD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define HBSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/hbsd_pkg.sv
// Shared widths, codes and types of the Huffman decoder.
package hbsd_pkg;

   localparam int SYMBOL_COUNT = 256;
   localparam int MAX_CODE_LEN = 16;
   localparam int NODE_DEPTH   = 511;

   localparam int TYPE_W   = 2;
   localparam int SYM_W    = 8;
   localparam int CODE_W   = 16;
   localparam int LEN_W    = 5;
   localparam int CNT_W    = 32;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;

   localparam int IDX_W     = $clog2(NODE_DEPTH);
   localparam int NF_W      = $clog2(NODE_DEPTH + 1);
   localparam int POS_W     = $clog2(MAX_CODE_LEN);
   localparam int BIT_IDX_W = $clog2(BYTE_W);

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_LOAD  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_DATA  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OFF_TREE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

   // one node of the code tree; child index zero means no child
   typedef struct packed {
      logic [SYM_W-1:0] sym;
      logic             leaf;
      logic [IDX_W-1:0] right;
      logic [IDX_W-1:0] left;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   // node memory access issued by the sequencer
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      node_type         wdata;
      logic             re;
      logic [IDX_W-1:0] raddr;
   } ram_ctl_type;

   // result or end-of-request flush handed to the output stage
   typedef struct packed {
      logic                emit;
      logic                flush;
      logic [SYM_W-1:0]    symbol;
      logic                done;
      logic [STATUS_W-1:0] status;
   } res_type;

endpackage

### sv/huffman_bit_serial_decoder_core.sv
// Clear and ignored requests finish in S_IDLE. A dictionary entry runs S_LD_STEP for
// each code bit, then S_LD_LEAF and S_FLUSH. A data byte runs S_BY_STEP and S_BY_CHECK
// per decoded bit, then S_BY_END and S_FLUSH; each tree step waits on the registered node read.
// One request at a time; req_ready is low while a request is in work.
// Synchronous reset empties the tree (root in flops, allocation count back to one) at once.
// Node memory is never swept: only nodes below the allocation count are ever read.
module huffman_bit_serial_decoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [hbsd_pkg::TYPE_W-1:0]       req_type,
   input  logic [hbsd_pkg::SYM_W-1:0]        req_entry_symbol,
   input  logic [hbsd_pkg::CODE_W-1:0]       req_entry_code,
   input  logic [hbsd_pkg::LEN_W-1:0]        req_entry_length,
   input  logic [hbsd_pkg::CNT_W-1:0]        req_entry_count,
   input  logic [hbsd_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                              req_final_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [hbsd_pkg::SYM_W-1:0]        rsp_symbol,
   output logic                              rsp_last_of_run,
   output logic                              rsp_stream_done,
   output logic [hbsd_pkg::STATUS_W-1:0]     rsp_status
);

   hbsd_pkg::ram_ctl_type             ram_ctl;
   logic [hbsd_pkg::NODE_W-1:0]       ram_rdata;
   hbsd_pkg::res_type                 res;
   logic                              stall;

   // insert / walk sequencer
   hbsd_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_entry_symbol (req_entry_symbol),
      .req_entry_code   (req_entry_code),
      .req_entry_length (req_entry_length),
      .req_entry_count  (req_entry_count),
      .req_data_byte    (req_data_byte),
      .req_final_byte   (req_final_byte),
      .ram_ctl          (ram_ctl),
      .ram_rdata        (ram_rdata),
      .res              (res),
      .stall            (stall)
   );

   // node table
   hbsd_ram #(
      .WIDTH (hbsd_pkg::NODE_W),
      .DEPTH (hbsd_pkg::NODE_DEPTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.we),
      .wr_addr (ram_ctl.waddr),
      .wr_data (ram_ctl.wdata),
      .rd_en   (ram_ctl.re),
      .rd_addr (ram_ctl.raddr),
      .rd_data (ram_rdata)
   );

   // result hold and output register
   hbsd_out u_out (
      .clock           (clock),
      .reset           (reset),
      .res             (res),
      .stall           (stall),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol      (rsp_symbol),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_stream_done (rsp_stream_done),
      .rsp_status      (rsp_status)
   );

endmodule

### sv/hbsd_ram.sv
// Generic simple dual-port RAM with registered read data.
module hbsd_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 511
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/hbsd_out.sv
// Output stage: holds one result back until its last-of-request flag is known.
`include "huffman_bit_serial_decoder_core_defines.svh"

module hbsd_out (
   input  logic                              clock,
   input  logic                              reset,
   input  hbsd_pkg::res_type                 res,
   output logic                              stall,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [hbsd_pkg::SYM_W-1:0]        rsp_symbol,
   output logic                              rsp_last_of_run,
   output logic                              rsp_stream_done,
   output logic [hbsd_pkg::STATUS_W-1:0]     rsp_status
);

   logic                          pend_valid_ff, pend_valid_in;
   logic [hbsd_pkg::SYM_W-1:0]    pend_sym_ff, pend_sym_in;
   logic                          pend_done_ff, pend_done_in;
   logic [hbsd_pkg::STATUS_W-1:0] pend_status_ff, pend_status_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [hbsd_pkg::SYM_W-1:0]    rsp_sym_ff, rsp_sym_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_done_ff, rsp_done_in;
   logic [hbsd_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic out_free;
   logic push;
   logic push_last;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // a held result moves on when a newer one arrives or the request ends
   always_comb begin
      stall          = 1'b0;
      push           = 1'b0;
      push_last      = 1'b0;
      pend_valid_in  = pend_valid_ff;
      pend_sym_in    = pend_sym_ff;
      pend_done_in   = pend_done_ff;
      pend_status_in = pend_status_ff;
      if (res.emit) begin
         if (pend_valid_ff && !out_free) begin
            stall = 1'b1;
         end else begin
            push           = pend_valid_ff;
            pend_valid_in  = 1'b1;
            pend_sym_in    = res.symbol;
            pend_done_in   = res.done;
            pend_status_in = res.status;
         end
      end else if (res.flush && pend_valid_ff) begin
         if (!out_free) begin
            stall = 1'b1;
         end else begin
            push          = 1'b1;
            push_last     = 1'b1;
            pend_valid_in = 1'b0;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sym_in    = rsp_sym_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_status_in = rsp_status_ff;
      if (push) begin
         rsp_valid_in  = 1'b1;
         rsp_sym_in    = pend_sym_ff;
         rsp_last_in   = push_last;
         rsp_done_in   = pend_done_ff;
         rsp_status_in = pend_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_sym_ff    <= pend_sym_in;
      pend_done_ff   <= pend_done_in;
      pend_status_ff <= pend_status_in;
      rsp_sym_ff     <= rsp_sym_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_symbol      = rsp_sym_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_stream_done = rsp_done_ff;
   assign rsp_status      = rsp_status_ff;

   `HBSD_ASSERT_NEXT(a_flush_empties, res.flush && !stall, !pend_valid_ff, "flush left a held result")

endmodule

### sv/hbsd_seq.sv
// Sequencer: tree insert for dictionary entries and bit-serial tree walk.
`include "huffman_bit_serial_decoder_core_defines.svh"

module hbsd_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [hbsd_pkg::TYPE_W-1:0]       req_type,
   input  logic [hbsd_pkg::SYM_W-1:0]        req_entry_symbol,
   input  logic [hbsd_pkg::CODE_W-1:0]       req_entry_code,
   input  logic [hbsd_pkg::LEN_W-1:0]        req_entry_length,
   input  logic [hbsd_pkg::CNT_W-1:0]        req_entry_count,
   input  logic [hbsd_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                              req_final_byte,
   output hbsd_pkg::ram_ctl_type             ram_ctl,
   input  logic [hbsd_pkg::NODE_W-1:0]       ram_rdata,
   output hbsd_pkg::res_type                 res,
   input  logic                              stall
);

   localparam int SYMW1 = hbsd_pkg::SYM_W + 1;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_LD_STEP  = 7'b0000010,
      S_LD_LEAF  = 7'b0000100,
      S_BY_STEP  = 7'b0001000,
      S_BY_CHECK = 7'b0010000,
      S_BY_END   = 7'b0100000,
      S_FLUSH    = 7'b1000000
   } state_type;

   state_type                        state_ff, state_in;
   logic [hbsd_pkg::IDX_W-1:0]       root_left_ff, root_left_in;
   logic [hbsd_pkg::IDX_W-1:0]       root_right_ff, root_right_in;
   logic [hbsd_pkg::NF_W-1:0]        next_free_ff, next_free_in;
   logic [hbsd_pkg::IDX_W-1:0]       walk_ff, walk_in;
   logic [hbsd_pkg::CNT_W-1:0]       exp_ff, exp_in;
   logic [hbsd_pkg::CNT_W-1:0]       dec_ff, dec_in;
   logic                             fin_ff, fin_in;

   logic [hbsd_pkg::IDX_W-1:0]       node_ff, node_in;
   logic                             fresh_ff, fresh_in;
   logic [hbsd_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [hbsd_pkg::CODE_W-1:0]      code_ff, code_in;
   logic [hbsd_pkg::SYM_W-1:0]       sym_ff, sym_in;
   logic [hbsd_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [hbsd_pkg::BYTE_W-1:0]      byte_ff, byte_in;
   logic                             final_ff, final_in;
   logic [hbsd_pkg::BIT_IDX_W-1:0]   bidx_ff, bidx_in;

   hbsd_pkg::node_type               rd_word;
   hbsd_pkg::node_type               root_word;
   hbsd_pkg::node_type               ld_word;
   hbsd_pkg::node_type               by_word;
   hbsd_pkg::node_type               new_word;
   logic                             ld_bit;
   logic                             by_bit;
   logic [hbsd_pkg::IDX_W-1:0]       ld_child;
   logic [hbsd_pkg::IDX_W-1:0]       by_child;
   logic [hbsd_pkg::IDX_W-1:0]       free_idx;
   logic                             table_full;
   logic [hbsd_pkg::LEN_W-1:0]       len_eff;
   logic [hbsd_pkg::CNT_W-1:0]       dec_next;
   logic                             accept;

   // current node word: root lives in flops, a fresh node is known empty
   assign rd_word   = hbsd_pkg::node_type'(ram_rdata);
   assign root_word = '{sym: '0, leaf: 1'b0, right: root_right_ff, left: root_left_ff};
   assign ld_word   = (node_ff == '0) ? root_word : (fresh_ff ? '0 : rd_word);
   assign by_word   = (walk_ff == '0) ? root_word : rd_word;
   assign ld_bit    = code_ff[pos_ff];
   assign by_bit    = byte_ff[bidx_ff];
   assign ld_child  = ld_bit ? ld_word.right : ld_word.left;
   assign by_child  = by_bit ? by_word.right : by_word.left;
   assign free_idx  = hbsd_pkg::IDX_W'(next_free_ff);
   assign table_full = next_free_ff >= hbsd_pkg::NF_W'(hbsd_pkg::NODE_DEPTH);
   assign len_eff   = (req_entry_length > hbsd_pkg::LEN_W'(hbsd_pkg::MAX_CODE_LEN))
                      ? hbsd_pkg::LEN_W'(hbsd_pkg::MAX_CODE_LEN) : req_entry_length;
   assign dec_next  = rd_word.leaf ? dec_ff + hbsd_pkg::CNT_W'(1) : dec_ff;
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   // parent word with the new child linked in
   always_comb begin
      new_word = ld_word;
      if (ld_bit) begin
         new_word.right = free_idx;
      end else begin
         new_word.left = free_idx;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      root_left_in  = root_left_ff;
      root_right_in = root_right_ff;
      next_free_in  = next_free_ff;
      walk_in       = walk_ff;
      exp_in        = exp_ff;
      dec_in        = dec_ff;
      fin_in        = fin_ff;
      node_in       = node_ff;
      fresh_in      = fresh_ff;
      pos_in        = pos_ff;
      code_in       = code_ff;
      sym_in        = sym_ff;
      cnt_in        = cnt_ff;
      byte_in       = byte_ff;
      final_in      = final_ff;
      bidx_in       = bidx_ff;
      ram_ctl       = '0;
      res           = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_type)
                  hbsd_pkg::REQ_CLEAR: begin
                     root_left_in  = '0;
                     root_right_in = '0;
                     next_free_in  = hbsd_pkg::NF_W'(1);
                     walk_in       = '0;
                     exp_in        = '0;
                     dec_in        = '0;
                     fin_in        = 1'b0;
                  end
                  hbsd_pkg::REQ_LOAD: begin
                     // zero length or out-of-range symbol is dropped
                     if (req_entry_length != '0 &&
                         {1'b0, req_entry_symbol} < SYMW1'(hbsd_pkg::SYMBOL_COUNT)) begin
                        sym_in   = req_entry_symbol;
                        code_in  = req_entry_code;
                        cnt_in   = req_entry_count;
                        node_in  = '0;
                        fresh_in = 1'b0;
                        pos_in   = hbsd_pkg::POS_W'(len_eff - hbsd_pkg::LEN_W'(1));
                        state_in = S_LD_STEP;
                     end
                  end
                  hbsd_pkg::REQ_DATA: begin
                     if (!fin_ff) begin
                        byte_in       = req_data_byte;
                        final_in      = req_final_byte;
                        bidx_in       = hbsd_pkg::BIT_IDX_W'(hbsd_pkg::BYTE_W - 1);
                        ram_ctl.re    = 1'b1;
                        ram_ctl.raddr = walk_ff;
                        state_in      = S_BY_STEP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LD_STEP: begin
            if (ld_child != '0) begin
               // existing branch: follow it
               node_in       = ld_child;
               fresh_in      = 1'b0;
               ram_ctl.re    = 1'b1;
               ram_ctl.raddr = ld_child;
               if (pos_ff == '0) begin
                  state_in = S_LD_LEAF;
               end else begin
                  pos_in = pos_ff - hbsd_pkg::POS_W'(1);
               end
            end else if (table_full) begin
               res.emit   = 1'b1;
               res.symbol = '0;
               res.done   = 1'b0;
               res.status = hbsd_pkg::ST_FULL;
               if (!stall) begin
                  // a node made just before still has to be emptied
                  if (fresh_ff) begin
                     ram_ctl.we    = 1'b1;
                     ram_ctl.waddr = node_ff;
                     ram_ctl.wdata = '0;
                  end
                  state_in = S_FLUSH;
               end
            end else begin
               // allocate a node and link it under the current one
               if (node_ff == '0) begin
                  root_left_in  = new_word.left;
                  root_right_in = new_word.right;
               end else begin
                  ram_ctl.we    = 1'b1;
                  ram_ctl.waddr = node_ff;
                  ram_ctl.wdata = new_word;
               end
               node_in      = free_idx;
               fresh_in     = 1'b1;
               next_free_in = next_free_ff + hbsd_pkg::NF_W'(1);
               if (pos_ff == '0) begin
                  state_in = S_LD_LEAF;
               end else begin
                  pos_in = pos_ff - hbsd_pkg::POS_W'(1);
               end
            end
         end
         S_LD_LEAF: begin
            // mark leaf, keep any children
            ram_ctl.we         = 1'b1;
            ram_ctl.waddr      = node_ff;
            ram_ctl.wdata      = ld_word;
            ram_ctl.wdata.leaf = 1'b1;
            ram_ctl.wdata.sym  = sym_ff;
            exp_in             = exp_ff + cnt_ff;
            state_in           = S_FLUSH;
         end
         S_BY_STEP: begin
            if (by_child == '0) begin
               // path leaves the tree: error result, rest of byte dropped
               res.emit   = 1'b1;
               res.symbol = '0;
               res.done   = (dec_ff == exp_ff);
               res.status = hbsd_pkg::ST_OFF_TREE;
               if (!stall) begin
                  walk_in  = '0;
                  state_in = S_BY_END;
               end
            end else begin
               walk_in       = by_child;
               ram_ctl.re    = 1'b1;
               ram_ctl.raddr = by_child;
               state_in      = S_BY_CHECK;
            end
         end
         S_BY_CHECK: begin
            if (rd_word.leaf) begin
               res.emit   = 1'b1;
               res.symbol = rd_word.sym;
               res.done   = (dec_next == exp_ff);
               res.status = hbsd_pkg::ST_OK;
            end
            if (!(rd_word.leaf && stall)) begin
               dec_in = dec_next;
               if (rd_word.leaf) begin
                  walk_in = '0;
               end
               if (dec_next == exp_ff) begin
                  fin_in   = 1'b1;
                  state_in = S_BY_END;
               end else if (bidx_ff == '0) begin
                  state_in = S_BY_END;
               end else begin
                  bidx_in  = bidx_ff - hbsd_pkg::BIT_IDX_W'(1);
                  state_in = S_BY_STEP;
               end
            end
         end
         S_BY_END: begin
            if (final_ff) begin
               fin_in  = 1'b1;
               walk_in = '0;
            end
            state_in = S_FLUSH;
         end
         S_FLUSH: begin
            res.flush = 1'b1;
            if (!stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         root_left_ff  <= '0;
         root_right_ff <= '0;
         next_free_ff  <= hbsd_pkg::NF_W'(1);
         walk_ff       <= '0;
         exp_ff        <= '0;
         dec_ff        <= '0;
         fin_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         root_left_ff  <= root_left_in;
         root_right_ff <= root_right_in;
         next_free_ff  <= next_free_in;
         walk_ff       <= walk_in;
         exp_ff        <= exp_in;
         dec_ff        <= dec_in;
         fin_ff        <= fin_in;
      end
   end

   // per-request working registers
   always_ff @(posedge clock) begin
      node_ff  <= node_in;
      fresh_ff <= fresh_in;
      pos_ff   <= pos_in;
      code_ff  <= code_in;
      sym_ff   <= sym_in;
      cnt_ff   <= cnt_in;
      byte_ff  <= byte_in;
      final_ff <= final_in;
      bidx_ff  <= bidx_in;
   end

   `HBSD_ASSERT_SAME(a_wr_addr, ram_ctl.we, ram_ctl.waddr != '0 && hbsd_pkg::NF_W'(ram_ctl.waddr) < next_free_ff, "node write outside allocated range")
   `HBSD_ASSERT_SAME(a_walk_child, state_ff == S_BY_CHECK, walk_ff != '0, "walk check at root")
   `HBSD_ASSERT_NEXT(a_fin_ignore, state_ff == S_IDLE && fin_ff && req_valid && req_type == hbsd_pkg::REQ_DATA, state_ff == S_IDLE, "data byte decoded after stream finished")

endmodule
